/* hdl/per_flow_sequence_loss_monitor_assert.svh */
// Assertion macros for the flow loss monitor.
// Each macro expects signals named clock and reset in the including scope.
`ifndef PER_FLOW_SEQUENCE_LOSS_MONITOR_ASSERT_SVH
`define PER_FLOW_SEQUENCE_LOSS_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define PFSLM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PFSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pfslm_pkg.sv */
`timescale 1ns / 1ps
package pfslm_pkg;

   localparam int KEY_W       = 32;
   localparam int SEQ_W       = 31;
   localparam int CNT_W32     = 32;
   localparam int SCALE_W     = 8;
   localparam int PROD_W      = CNT_W32 + SCALE_W;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (3 * CNT_W32 + SEQ_W + 2);

   localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd2;
   localparam logic               OP_MSG      = 1'b0;
   localparam logic               OP_TICK     = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0] last_seq;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

/* hdl/pfslm_ram.sv */
`timescale 1ns / 1ps
module pfslm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/per_flow_sequence_loss_monitor.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+--------------------------------------
// req       | in        | req_tvalid/req_tready | tuser: op; tdata: message fields
// rsp       | out       | rsp_tvalid/rsp_tready | tdata: totals, rate, per-item flags
// csr       | in        | csr_valid/csr_ready   | csr_data: rate_scale
//
// A rate tick or a rejected message goes from accept to DONE, then back to IDLE.
// A message scans entries in LOOK/CMP pairs until its key matches; a new key scans
// all stored flows. The scan reads one entry per LOOK/CMP pair through the single
// flow RAM read port. Reset clears the fill count, not the RAM; no clearing pass.
// A result waiting on rsp_tready stalls the finishing item and so the next accept.
module per_flow_sequence_loss_monitor
   import pfslm_pkg::*;
#(
   parameter int FLOW_ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [64:34] seq_num, [33:18] pub_index, [17:2] app_id, [1] instance_alive,
   // [0] data_valid
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] op
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [128] table_full, [127] new_flow, [126:96] lost_now, [95:64] rate_value,
   // [63:32] lost_total, [31:0] received_total
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SCALE_W-1:0]     csr_data
);

   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int FILL_W = $clog2(FLOW_ENTRIES + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FLOW_ENTRIES);
   localparam int ENTRY_W = $bits(entry_type);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               op_ff, op_in;
   logic               ok_ff, ok_in;
   logic               hit_ff, hit_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [SEQ_W-1:0]   last_ff, last_in;
   logic [CNT_W32-1:0] recv_ff, recv_in;
   logic [CNT_W32-1:0] lost_ff, lost_in;
   logic [CNT_W32-1:0] intv_ff, intv_in;
   logic [CNT_W32-1:0] rate_ff, rate_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire, out_free, done_fire, rd_en, key_match, scan_end;
   logic [FILL_W-1:0] idx_next;
   entry_type rd_entry, wr_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;

   logic               is_msg, gap_pos, new_flow, tbl_full;
   logic [SEQ_W-1:0]   gap, lost_now;
   logic [CNT_W32:0]   lost_sum, recv_sum;
   logic [PROD_W-1:0]  prod;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   pfslm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_flow_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign rd_entry  = entry_type'(rd_word);
   assign key_match = (rd_entry.key == key_ff);
   assign idx_next  = FILL_W'(idx_ff) + 1'b1;
   assign scan_end  = (idx_next == fill_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_TICK || !(req_tdata[0] && req_tdata[1]) ||
                   fill_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: state_in = ST_CMP;
         ST_CMP: begin
            if (key_match || scan_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      done_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_LOOK: rd_en      = 1'b1;
         ST_CMP:  ;
         ST_DONE: done_fire  = out_free;
         default: ;
      endcase
   end

   // result arithmetic
   always_comb begin
      is_msg   = (op_ff == OP_MSG) && ok_ff;
      gap_pos  = hit_ff && ({1'b0, seq_ff} > ({1'b0, last_ff} + 32'd1));
      gap      = seq_ff - last_ff - 1'b1;
      lost_now = (is_msg && gap_pos) ? gap : '0;
      new_flow = is_msg && !hit_ff;
      tbl_full = new_flow && (fill_ff == FILL_MAX);
      lost_sum = {1'b0, lost_ff} + (CNT_W32 + 1)'(lost_now);
      recv_sum = {1'b0, recv_ff} + (CNT_W32 + 1)'(1);
      prod     = PROD_W'(intv_ff) * PROD_W'(scale_ff);
   end

   assign wr_en   = done_fire && is_msg && !tbl_full;
   assign wr_addr = hit_ff ? idx_ff : fill_ff[IDX_W-1:0];
   assign wr_entry = '{last_seq: seq_ff, key: key_ff};

   always_comb begin
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      op_in    = op_ff;
      ok_in    = ok_ff;
      hit_in   = hit_ff;
      key_in   = key_ff;
      seq_in   = seq_ff;
      last_in  = last_ff;
      recv_in  = recv_ff;
      lost_in  = lost_ff;
      intv_in  = intv_ff;
      rate_in  = rate_ff;
      scale_in = scale_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         scale_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         op_in  = req_tuser;
         ok_in  = req_tdata[0] && req_tdata[1];
         key_in = {req_tdata[17:2], req_tdata[33:18]};
         seq_in = req_tdata[64:34];
         idx_in = '0;
         hit_in = 1'b0;
      end
      if (state_ff == ST_CMP) begin
         if (key_match) begin
            hit_in  = 1'b1;
            last_in = rd_entry.last_seq;
         end else if (!scan_end) begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (done_fire) begin
         if (op_ff == OP_TICK) begin
            rate_in = (prod[PROD_W-1:CNT_W32] != '0) ? '1 : prod[CNT_W32-1:0];
            intv_in = '0;
         end else if (is_msg) begin
            recv_in = recv_sum[CNT_W32] ? '1 : recv_sum[CNT_W32-1:0];
            intv_in = (intv_ff == '1) ? intv_ff : intv_ff + 1'b1;
            lost_in = lost_sum[CNT_W32] ? '1 : lost_sum[CNT_W32-1:0];
            if (new_flow && !tbl_full) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {RSP_PAD_W'(0), tbl_full, new_flow, lost_now,
                         rate_in, lost_in, recv_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         recv_ff      <= '0;
         lost_ff      <= '0;
         intv_ff      <= '0;
         rate_ff      <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         recv_ff      <= recv_in;
         lost_ff      <= lost_in;
         intv_ff      <= intv_in;
         rate_ff      <= rate_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      ok_ff       <= ok_in;
      hit_ff      <= hit_in;
      key_ff      <= key_in;
      seq_ff      <= seq_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "per_flow_sequence_loss_monitor_assert.svh"

   `PFSLM_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_MAX, "fill count beyond table size")
   `PFSLM_ASSERT_NOW(a_wr_in_done, wr_en, state_ff == ST_DONE, "flow RAM write outside finish")
   `PFSLM_ASSERT_NEXT(a_accept_busy, req_fire, state_ff != ST_IDLE, "accepted beat left idle")
   `PFSLM_ASSERT_NOW(a_full_is_new, done_fire && tbl_full, new_flow && !hit_ff,
                     "table full flagged on a known flow")

endmodule

/* test/tb_per_flow_sequence_loss_monitor.sv */
`timescale 1ns / 1ps
module tb_per_flow_sequence_loss_monitor;
   import pfslm_pkg::*;

   localparam int FLOW_SLOTS = 16;
   localparam int SLOWEST_ITEM_CYCLES = 2 * FLOW_SLOTS + 8;

   typedef struct packed {
      logic        op;
      logic        data_valid;
      logic        instance_alive;
      logic [15:0] app_id;
      logic [15:0] pub_index;
      logic [30:0] seq_num;
   } flow_msg_type;

   typedef struct packed {
      logic [31:0] received_total;
      logic [31:0] lost_total;
      logic [31:0] rate_value;
      logic [30:0] lost_now;
      logic        new_flow;
      logic        table_full;
   } flow_stats_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [64:34] seq_num, [33:18] pub_index, [17:2] app_id, [1] instance_alive,
   // [0] data_valid
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] op
   logic                   req_tuser = OP_MSG;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [128] table_full, [127] new_flow, [126:96] lost_now, [95:64] rate_value,
   // [63:32] lost_total, [31:0] received_total
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [SCALE_W-1:0]     csr_data = SCALE_RESET;

   // Predicted block state
   logic               flow_used [FLOW_SLOTS];
   logic [KEY_W-1:0]   flow_key [FLOW_SLOTS];
   logic [SEQ_W-1:0]   flow_last_seq [FLOW_SLOTS];
   logic [31:0]        received_count;
   logic [31:0]        lost_count;
   logic [31:0]        interval_count;
   logic [31:0]        rate_now;
   logic [SCALE_W-1:0] rate_scale_model;

   flow_stats_type pending_stats [$];
   flow_stats_type observed_stats;
   flow_stats_type awaited_stats;
   int             mismatch_count = 0;
   int             req_idle_pct = 0;
   int             rsp_stall_pct = 0;

   per_flow_sequence_loss_monitor #(
      .FLOW_ENTRIES(FLOW_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] add_saturated(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic flow_stats_type account_message(input flow_msg_type m);
      flow_stats_type   r;
      logic [KEY_W-1:0] key;
      logic [39:0]      product;
      logic [31:0]      next_seq;
      logic [31:0]      gap;
      int               hit;
      int               free_slot;
      r = '0;
      key = {m.app_id, m.pub_index};
      hit = -1;
      free_slot = -1;
      if (m.op == OP_TICK) begin
         product = interval_count * rate_scale_model;
         rate_now = (product[39:32] != 0) ? 32'hFFFF_FFFF : product[31:0];
         interval_count = '0;
      end else if (m.data_valid && m.instance_alive) begin
         for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (flow_used[i]) begin
               if (hit < 0 && flow_key[i] == key) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit >= 0) begin
            next_seq = {1'b0, flow_last_seq[hit]} + 32'd1;
            if ({1'b0, m.seq_num} > next_seq) begin
               gap = {1'b0, m.seq_num} - next_seq;
               r.lost_now = gap[30:0];
               lost_count = add_saturated(lost_count, gap);
            end
            flow_last_seq[hit] = m.seq_num;
         end else begin
            r.new_flow = 1'b1;
            if (free_slot >= 0) begin
               flow_used[free_slot] = 1'b1;
               flow_key[free_slot] = key;
               flow_last_seq[free_slot] = m.seq_num;
            end else begin
               r.table_full = 1'b1;
            end
         end
         received_count = add_saturated(received_count, 32'd1);
         interval_count = add_saturated(interval_count, 32'd1);
      end
      r.received_total = received_count;
      r.lost_total = lost_count;
      r.rate_value = rate_now;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t ns: %s got %h expected %h", $time, what, got, want);
   endtask

   // Called at a falling edge; returns at a falling edge with req_tvalid still high.
   task automatic send_message(input flow_msg_type m);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m.op;
      req_tdata  <= {7'b0, m.seq_num, m.pub_index, m.app_id, m.instance_alive, m.data_valid};
      do @(posedge clock); while (!req_tready);
      pending_stats.insert(pending_stats.size(), account_message(m));
      @(negedge clock);
   endtask

   task automatic send_flow(input logic [15:0] app, input logic [15:0] pub,
                            input logic [30:0] seq);
      flow_msg_type m;
      m = '{OP_MSG, 1'b1, 1'b1, app, pub, seq};
      send_message(m);
   endtask

   // Drop valid and hold until every result is back, then let the block settle.
   task automatic wait_drained(input int settle_cycles);
      req_tvalid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_rate_scale(input logic [SCALE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      rate_scale_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed_stats = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                           rsp_tdata[126:96], rsp_tdata[127], rsp_tdata[128]};
         if (pending_stats.size() == 0) begin
            report_mismatch("result beat with nothing pending", observed_stats.received_total,
                            32'h0);
         end else begin
            awaited_stats = pending_stats.pop_front();
            if (observed_stats.received_total !== awaited_stats.received_total)
               report_mismatch("received_total", observed_stats.received_total,
                               awaited_stats.received_total);
            if (observed_stats.lost_total !== awaited_stats.lost_total)
               report_mismatch("lost_total", observed_stats.lost_total,
                               awaited_stats.lost_total);
            if (observed_stats.rate_value !== awaited_stats.rate_value)
               report_mismatch("rate_value", observed_stats.rate_value,
                               awaited_stats.rate_value);
            if (observed_stats.lost_now !== awaited_stats.lost_now)
               report_mismatch("lost_now", {1'b0, observed_stats.lost_now},
                               {1'b0, awaited_stats.lost_now});
            if (observed_stats.new_flow !== awaited_stats.new_flow)
               report_mismatch("new_flow", {31'b0, observed_stats.new_flow},
                               {31'b0, awaited_stats.new_flow});
            if (observed_stats.table_full !== awaited_stats.table_full)
               report_mismatch("table_full", {31'b0, observed_stats.table_full},
                               {31'b0, awaited_stats.table_full});
         end
      end
   end

   // In order, gap, repeat and backward numbers on one flow, both ends of the range.
   task automatic test_sequence_tracking();
      send_flow(16'h0000, 16'h0000, 31'd0);
      send_flow(16'h0000, 16'h0000, 31'd0);
      send_flow(16'h0000, 16'h0000, 31'd1);
      send_flow(16'h0000, 16'h0000, 31'h7FFF_FFFF);
      send_flow(16'h0000, 16'h0000, 31'd3);
      send_flow(16'h0000, 16'h0000, 31'd4);
      send_flow(16'h0000, 16'h0000, 31'd9);
   endtask

   task automatic test_rejected_messages();
      flow_msg_type m;
      m = '{OP_MSG, 1'b0, 1'b1, 16'h0000, 16'h0000, 31'd50};
      send_message(m);
      m = '{OP_MSG, 1'b1, 1'b0, 16'h0000, 16'h0000, 31'd60};
      send_message(m);
      m = '{OP_MSG, 1'b0, 1'b0, 16'($urandom), 16'($urandom), 31'($urandom)};
      send_message(m);
   endtask

   // Data fields ride along on a tick and must be ignored.
   task automatic test_rate_tick();
      flow_msg_type m;
      m = '{OP_TICK, 1'b1, 1'b1, 16'h0000, 16'h0000, 31'd100};
      send_message(m);
      m = '{OP_TICK, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF};
      send_message(m);
      send_flow(16'h0000, 16'h0000, 31'd10);
      m = '{OP_TICK, 1'b1, 1'b0, 16'($urandom), 16'($urandom), 31'($urandom)};
      send_message(m);
   endtask

   // Fill the remaining slots, then push a new key that cannot be stored, twice.
   task automatic test_table_capacity();
      for (int k = 1; k < FLOW_SLOTS; k++) begin
         if (k == FLOW_SLOTS - 1)
            send_flow(16'hFFFF, 16'hFFFF, 31'($urandom));
         else
            send_flow(16'($urandom), {4'(k), 12'($urandom)}, 31'($urandom));
      end
      send_flow(16'h8000, 16'h0001, 31'd5);
      send_flow(16'h8000, 16'h0001, 31'd6);
      send_flow(16'hFFFF, 16'hFFFF, 31'($urandom));
   endtask

   function automatic flow_msg_type make_traffic_item();
      flow_msg_type     m;
      logic [SEQ_W-1:0] last;
      int               pick;
      int               slot;
      m = '{OP_MSG, 1'b1, 1'b1, 16'($urandom), 16'($urandom), 31'($urandom)};
      pick = $urandom_range(99);
      if (pick < 7) begin
         m.op = OP_TICK;
         m.data_valid = 1'($urandom);
         m.instance_alive = 1'($urandom);
      end else if (pick < 14) begin
         {m.data_valid, m.instance_alive} = 2'($urandom_range(2));
      end else if (pick >= 20) begin
         slot = $urandom_range(FLOW_SLOTS - 1);
         last = flow_last_seq[slot];
         {m.app_id, m.pub_index} = flow_key[slot];
         pick = $urandom_range(99);
         if (pick < 55)
            m.seq_num = last + 31'd1;
         else if (pick < 70)
            m.seq_num = last + 31'd1 + 31'($urandom_range(16, 1));
         else if (pick < 78)
            m.seq_num = last;
         else if (pick < 86)
            m.seq_num = 31'($urandom_range(int'(last), 0));
         else if (pick < 93)
            m.seq_num = last + 31'($urandom_range(1 << 20, 2));
         else
            m.seq_num = last + 31'd2;
      end
      return m;
   endfunction

   task automatic test_random_traffic(input logic [SCALE_W-1:0] scale, input int count,
                                      input int idle_pct, input int stall_pct);
      wait_drained(4);
      write_rate_scale(scale);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_message(make_traffic_item());
   endtask

   // Large jumps on one flow drive the lost total into saturation.
   task automatic test_lost_saturation();
      repeat (3) begin
         send_flow(16'h0000, 16'h0000, 31'd0);
         send_flow(16'h0000, 16'h0000, 31'h7FFF_FFFF);
      end
      send_flow(16'h0000, 16'h0000, 31'd1);
      send_flow(16'h0000, 16'h0000, 31'd40);
   endtask

   initial begin
      for (int i = 0; i < FLOW_SLOTS; i++) flow_used[i] = 1'b0;
      received_count = '0;
      lost_count = '0;
      interval_count = '0;
      rate_now = '0;
      rate_scale_model = SCALE_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 24;
      rsp_stall_pct = 70;
      test_sequence_tracking();
      test_rejected_messages();
      test_rate_tick();
      test_table_capacity();
      test_random_traffic(8'd255, 420, 24, 70);
      test_random_traffic(8'd1, 420, 70, 24);
      test_random_traffic(8'd0, 200, 0, 0);
      test_random_traffic(8'($urandom_range(254, 3)), 200, 0, 0);
      test_lost_saturation();
      wait_drained(SLOWEST_ITEM_CYCLES);
      if (mismatch_count == 0 && pending_stats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* per_flow_sequence_loss_monitor.f */
+incdir+hdl
hdl/pfslm_pkg.sv
hdl/pfslm_ram.sv
hdl/per_flow_sequence_loss_monitor.sv
test/tb_per_flow_sequence_loss_monitor.sv
